@@ src/rwmn_pkg.sv @@
// shared types, register codes and linear-level table builders for the rgb to nir mixer
package rwmn_pkg;

    localparam int LINEAR_FRAC_BITS_DEF = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 14;

    localparam int CHAN_W   = 8;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // working precision of the table builder
    localparam int WORK_BITS = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_RED   = 2'd0,
        REG_WEIGHT_GREEN = 2'd1,
        REG_WEIGHT_BLUE  = 2'd2,
        REG_GAMMA_ENABLE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] nir_level;
        logic              last_out;
    } pix_out_t;

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> WORK_BITS;
    endfunction

    function automatic logic [63:0] qpow5(logic [63:0] r);
        logic [63:0] r2;
        r2 = qmul(r, r);
        return qmul(qmul(r2, r2), r);
    endfunction

    // srgb to linear level, 1.0 is 2^f, evaluated at elaboration only
    function automatic logic [31:0] gamma_level(int unsigned c, int unsigned f);
        logic [63:0] u;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] y;
        logic [63:0] num;
        if (c <= 10)
        begin
            num = 64'd20 * 64'(c) * (64'd1 << f) + 64'd32946;
            return 32'(num / 64'd65892);
        end
        u  = (64'(1000 * c + 14025) << WORK_BITS) / 64'd269025;
        lo = 64'd0;
        hi = 64'd1 << WORK_BITS;
        // fifth root by bisection
        while (lo < hi)
        begin
            mid = (lo + hi + 64'd1) >> 1;
            if (qpow5(mid) <= u)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        y = qmul(qmul(u, u), qmul(lo, lo));
        return 32'((y + (64'd1 << (WORK_BITS - 1 - f))) >> (WORK_BITS - f));
    endfunction

    // c/255 rounded half up, 1.0 is 2^f
    function automatic logic [31:0] plain_level(int unsigned c, int unsigned f);
        logic [63:0] num;
        num = 64'(c) * (64'd1 << (f + 1)) + 64'd255;
        return 32'(num / 64'd510);
    endfunction

endpackage

@@ src/rgb_weighted_mix_to_nir_unit.sv @@
// rgb to pseudo near-infrared mixer: table lookup, weighting, summing and rounding pipeline
//
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+----------------------------
//  pixel   | in_valid, in_stall, in_data      | in        | red, green, blue, last_pixel
//  level   | out_valid, out_stall, out_data   | out       | nir_level, last_out
//  config  | cfg_wr_en, cfg_index, cfg_data   | in        | register write
//
// one item per cycle sustained while out_stall is low; registered stages: lookup, multiply, sum, clamp/scale
// each stage holds its item only while the stage after it is full and held, so bubbles close up
// in_stall rises only when every stage is full and out_stall holds the output register
// no clearing pass after reset: the linear tables are constants
// reset sets the weights to red only and turns gamma off
module rgb_weighted_mix_to_nir_unit #(
    parameter int LINEAR_FRAC_BITS = rwmn_pkg::LINEAR_FRAC_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = rwmn_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  rwmn_pkg::pix_in_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output rwmn_pkg::pix_out_t                 out_data,
    input  logic                               cfg_wr_en,
    input  logic [rwmn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rwmn_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rwmn_pkg::*;

    localparam int F     = LINEAR_FRAC_BITS;
    localparam int FW    = LINEAR_FRAC_BITS + WEIGHT_FRAC_BITS;
    localparam int LW    = F + 1;
    localparam int PW    = WEIGHT_W + LW + 1;
    localparam int SW    = PW + 2;
    localparam int CW    = (SW > FW + 2) ? SW : FW + 2;
    localparam int KW    = FW + 1;
    localparam int MW    = FW + 9;
    localparam logic signed [CW-1:0] TOP  = CW'(1) << FW;
    localparam logic [MW-1:0]        HALF = MW'(1) << (FW - 1);

    // configuration registers
    logic signed [WEIGHT_W-1:0] weight_red_reg;
    logic signed [WEIGHT_W-1:0] weight_green_reg;
    logic signed [WEIGHT_W-1:0] weight_blue_reg;
    logic                       gamma_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_red_reg   <= 16'sh4000;
            weight_green_reg <= '0;
            weight_blue_reg  <= '0;
            gamma_enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_WEIGHT_RED:   weight_red_reg   <= cfg_data;
                REG_WEIGHT_GREEN: weight_green_reg <= cfg_data;
                REG_WEIGHT_BLUE:  weight_blue_reg  <= cfg_data;
                REG_GAMMA_ENABLE: gamma_enable_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // constant linear-level tables, built at elaboration
    logic [LW-1:0] gamma_tab [256];
    logic [LW-1:0] plain_tab [256];

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_tab
        assign gamma_tab[gi] = LW'(gamma_level(gi, F));
        assign plain_tab[gi] = LW'(plain_level(gi, F));
    end

    // stage ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: linear levels
    logic [LW-1:0] lin_r_reg, lin_g_reg, lin_b_reg;
    logic [LW-1:0] lin_r_next, lin_g_next, lin_b_next;
    logic          last1_reg;

    always_comb
    begin
        if (gamma_enable_reg)
        begin
            lin_r_next = gamma_tab[in_data.red];
            lin_g_next = gamma_tab[in_data.green];
            lin_b_next = gamma_tab[in_data.blue];
        end
        else
        begin
            lin_r_next = plain_tab[in_data.red];
            lin_g_next = plain_tab[in_data.green];
            lin_b_next = plain_tab[in_data.blue];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            lin_r_reg <= lin_r_next;
            lin_g_reg <= lin_g_next;
            lin_b_reg <= lin_b_next;
            last1_reg <= in_data.last_pixel;
        end
    end

    // stage 2: weighted products
    logic signed [PW-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic signed [PW-1:0] prod_r_next, prod_g_next, prod_b_next;
    logic                 last2_reg;

    always_comb
    begin
        prod_r_next = weight_red_reg   * $signed({1'b0, lin_r_reg});
        prod_g_next = weight_green_reg * $signed({1'b0, lin_g_reg});
        prod_b_next = weight_blue_reg  * $signed({1'b0, lin_b_reg});
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            prod_r_reg <= prod_r_next;
            prod_g_reg <= prod_g_next;
            prod_b_reg <= prod_b_next;
            last2_reg  <= last1_reg;
        end
    end

    // stage 3: exact sum
    logic signed [CW-1:0] sum_reg;
    logic signed [CW-1:0] sum_next;
    logic                 last3_reg;

    assign sum_next = CW'(prod_r_reg) + CW'(prod_g_reg) + CW'(prod_b_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            sum_reg   <= sum_next;
            last3_reg <= last2_reg;
        end
    end

    // stage 4: clamp to [0,1], scale by 255, round half up
    logic [KW-1:0]     clamp_val;
    logic [MW-1:0]     scaled;
    logic [CHAN_W-1:0] level_next;
    pix_out_t          out_reg;

    always_comb
    begin
        if (sum_reg < 0)
            clamp_val = '0;
        else if (sum_reg > TOP)
            clamp_val = KW'(TOP);
        else
            clamp_val = sum_reg[KW-1:0];
        scaled     = (MW'(clamp_val) << 8) - MW'(clamp_val) + HALF;
        level_next = scaled[FW+CHAN_W-1:FW];
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            out_reg.nir_level <= level_next;
            out_reg.last_out  <= last3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

    // input is held back only when the first stage is full
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg)
        else $error("input stalled with an empty first stage");

    // a held product stage keeps its item
    a_prod_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> ($stable(prod_r_reg) && $stable(prod_g_reg)
                               && $stable(prod_b_reg) && v2_reg))
        else $error("held product stage lost its item");

    // an item in a filled sum stage reaches the output when the output stage can take it
    a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rdy4) |=> out_valid)
        else $error("item from sum stage did not reach the output");

    // an empty sum stage with a ready output stage gives no result in the cycle after
    a_no_invented_item: assert property (@(posedge clk) disable iff (!rst_n)
        (!v3_reg && rdy4) |=> !out_valid)
        else $error("result appeared without an item behind it");

endmodule

@@ test/tb_rgb_weighted_mix_to_nir_unit.sv @@
// self-checking testbench for the rgb to pseudo near-infrared mixer
module tb_rgb_weighted_mix_to_nir_unit;
    import rwmn_pkg::*;

    localparam int LIN_FRAC   = LINEAR_FRAC_BITS_DEF;
    localparam int WGT_FRAC   = WEIGHT_FRAC_BITS_DEF;
    localparam int ROOT_FRAC  = 30;
    localparam int PIPE_DEPTH = 4;
    localparam int QUIET_LIMIT = 3000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    pix_in_t    in_data;
    logic       out_valid;
    logic       out_stall;
    pix_out_t   out_data;
    logic       cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register mirror
    shortint wt_red;
    shortint wt_green;
    shortint wt_blue;
    logic    gamma_on;

    logic [31:0] srgb_lut [256];
    pix_out_t    pending_levels [$];
    int          fail_count;
    int          quiet_cycles;
    int          in_idle_pct;
    int          out_idle_pct;
    int          hold_left;

    rgb_weighted_mix_to_nir_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // srgb decoding: linear segment near black, power curve above it
    function automatic logic [31:0] expected_gamma_level(int unsigned c);
        logic [63:0] base;
        logic [63:0] lo_root;
        logic [63:0] hi_root;
        logic [63:0] probe;
        logic [63:0] p2;
        logic [63:0] p5;
        logic [63:0] curve;
        if (c <= 10)
            return 32'((64'd20 * 64'(c) * (64'd1 << LIN_FRAC) + 64'd32946) / 64'd65892);
        base    = (64'(1000 * c + 14025) << ROOT_FRAC) / 64'd269025;
        lo_root = 64'd0;
        hi_root = 64'd1 << ROOT_FRAC;
        // largest fifth root of base that does not overshoot
        while (lo_root < hi_root)
        begin
            probe = (lo_root + hi_root + 64'd1) >> 1;
            p2 = (probe * probe) >> ROOT_FRAC;
            p5 = (((p2 * p2) >> ROOT_FRAC) * probe) >> ROOT_FRAC;
            if (p5 <= base)
                lo_root = probe;
            else
                hi_root = probe - 64'd1;
        end
        curve = (((base * base) >> ROOT_FRAC) * ((lo_root * lo_root) >> ROOT_FRAC)) >> ROOT_FRAC;
        return 32'((curve + (64'd1 << (ROOT_FRAC - 1 - LIN_FRAC))) >> (ROOT_FRAC - LIN_FRAC));
    endfunction

    function automatic longint channel_level(logic [7:0] c);
        if (gamma_on)
            return longint'(srgb_lut[c]);
        return longint'((64'(c) * (64'd1 << (LIN_FRAC + 1)) + 64'd255) / 64'd510);
    endfunction

    function automatic pix_out_t predict_nir(pix_in_t px);
        longint acc;
        longint top;
        logic [63:0] scaled;
        pix_out_t res;
        acc = longint'(wt_red) * channel_level(px.red)
            + longint'(wt_green) * channel_level(px.green)
            + longint'(wt_blue) * channel_level(px.blue);
        top = longint'(1) << (LIN_FRAC + WGT_FRAC);
        if (acc < 0)
            acc = 0;
        if (acc > top)
            acc = top;
        scaled = 64'(acc) * 64'd255 + (64'd1 << (LIN_FRAC + WGT_FRAC - 1));
        res.nir_level = 8'(scaled >> (LIN_FRAC + WGT_FRAC));
        res.last_out  = px.last_pixel;
        return res;
    endfunction

    function automatic pix_in_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic last);
        pix_in_t px;
        px.red        = r;
        px.green      = g;
        px.blue       = b;
        px.last_pixel = last;
        return px;
    endfunction

    function automatic logic [7:0] random_channel();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pix_in_t random_pixel();
        return make_pixel(random_channel(), random_channel(), random_channel(),
                          $urandom_range(7) == 0);
    endfunction

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WEIGHT_RED:   wt_red   = value;
            REG_WEIGHT_GREEN: wt_green = value;
            REG_WEIGHT_BLUE:  wt_blue  = value;
            REG_GAMMA_ENABLE: gamma_on = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_weights(shortint r, shortint g, shortint b);
        write_reg(REG_WEIGHT_RED, r);
        write_reg(REG_WEIGHT_GREEN, g);
        write_reg(REG_WEIGHT_BLUE, b);
    endtask

    // valid is left high after acceptance so back-to-back items go without a gap
    task automatic send_pixel(pix_in_t px);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        pending_levels.push_back(predict_nir(px));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic test_reset_weights();
        send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b1));
        send_pixel(make_pixel(8'd128, 8'd17, 8'd200, 1'b0));
        send_pixel(make_pixel(8'd1, 8'd254, 8'd3, 1'b1));
        wait_idle();
    endtask

    // half weight on full red lands exactly on .5 and must round up
    task automatic test_half_rounding();
        write_weights(16'sd8192, 16'sd0, 16'sd0);
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b1));
        wait_idle();
    endtask

    task automatic test_clamping();
        write_weights(16'sd32767, 16'sd32767, 16'sd32767);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b1));
        wait_idle();
        write_weights(-16'sd32768, -16'sd32768, -16'sd32768);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
        wait_idle();
        write_weights(16'sd32767, -16'sd32768, 16'sd0);
        send_pixel(make_pixel(8'd255, 8'd128, 8'd77, 1'b0));
        wait_idle();
    endtask

    // gamma register takes bit 0 only; straddle the knee between the segments
    task automatic test_gamma_knee();
        write_weights(16'sd3483, 16'sd11718, 16'sd1183);
        write_reg(REG_GAMMA_ENABLE, 16'h8001);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd10, 8'd10, 8'd10, 1'b1));
        send_pixel(make_pixel(8'd11, 8'd11, 8'd11, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 1'b1));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 1'b0));
        wait_idle();
        write_reg(REG_GAMMA_ENABLE, 16'hFFFE);
        send_pixel(make_pixel(8'd10, 8'd11, 8'd255, 1'b1));
        wait_idle();
    endtask

    task automatic test_random_settings();
        int mode;
        int r;
        int g;
        shortint pick [4];
        pick[0] = 16'sd32767;
        pick[1] = -16'sd32768;
        pick[2] = 16'sd0;
        pick[3] = 16'sd16384;
        for (int phase = 0; phase < 8; phase++)
        begin
            mode = phase % 4;
            case (mode)
                0:
                begin
                    r = $urandom_range(16384);
                    g = $urandom_range(16384 - r);
                    write_weights(16'(r), 16'(g), 16'(16384 - r - g));
                end
                1: write_weights(16'($urandom), 16'($urandom), 16'($urandom));
                2:
                begin
                    r = $urandom_range(32767);
                    g = -$urandom_range(8192);
                    write_weights(16'(r), 16'(g), 16'(16384 - r - g));
                end
                default: write_weights(pick[$urandom_range(3)], pick[$urandom_range(3)],
                                       pick[$urandom_range(3)]);
            endcase
            write_reg(REG_GAMMA_ENABLE, {15'($urandom), phase[1]});
            repeat (110) send_pixel(random_pixel());
            wait_idle();
        end
    endtask

    task automatic test_full_rate();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        write_weights(16'sd5461, 16'sd5461, 16'sd5462);
        repeat (150) send_pixel(random_pixel());
        wait_idle();
        in_idle_pct  = 29;
        out_idle_pct = 29;
    endtask

    // receiver holds off long enough for the pipeline to fill and push back
    task automatic test_output_hold();
        write_reg(REG_GAMMA_ENABLE, 16'h0001);
        hold_left = 300;
        repeat (60) send_pixel(random_pixel());
        wait_idle();
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge clk)
    begin : level_check
        pix_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_levels.size() == 0)
                report_failure($sformatf("unexpected item: level %0d last %0b",
                                         out_data.nir_level, out_data.last_out));
            else
            begin
                want = pending_levels.pop_front();
                if (out_data.nir_level !== want.nir_level || out_data.last_out !== want.last_out)
                    report_failure($sformatf("mismatch: expected level %0d last %0b, got level %0d last %0b",
                                             want.nir_level, want.last_out,
                                             out_data.nir_level, out_data.last_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_WEIGHT_RED;
        cfg_data     = '0;
        in_idle_pct  = 29;
        out_idle_pct = 29;
        hold_left    = 0;
        wt_red       = 16'sd16384;
        wt_green     = 16'sd0;
        wt_blue      = 16'sd0;
        gamma_on     = 1'b0;
        for (int c = 0; c < 256; c++)
            srgb_lut[c] = expected_gamma_level(c);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_weights();
        test_half_rounding();
        test_clamping();
        test_gamma_knee();
        test_random_settings();
        test_full_rate();
        test_output_hold();

        wait_idle();
        if (fail_count == 0 && pending_levels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
src/rwmn_pkg.sv
src/rgb_weighted_mix_to_nir_unit.sv
test/tb_rgb_weighted_mix_to_nir_unit.sv
